[design/ipv4_header_validator_macros.svh]
// assertion helpers shared by the checking code
`ifndef IPV4_HEADER_VALIDATOR_MACROS_SVH
`define IPV4_HEADER_VALIDATOR_MACROS_SVH

// condition holds in the same cycle as the trigger
`define IPV4HV_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("ipv4 header validator check failed");

// condition holds in the cycle after the trigger
`define IPV4HV_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("ipv4 header validator check failed");

`endif

[design/ipv4hv_pkg.sv]
package ipv4hv_pkg;

   localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [15:0] BYTE_COUNT_MAX   = 16'hFFFF;
   localparam logic [15:0] SUM_ALL_ONES     = 16'hFFFF;

   localparam logic [15:0] IDX_TOTAL_HI = 16'd2;
   localparam logic [15:0] IDX_TOTAL_LO = 16'd3;
   localparam logic [15:0] IDX_PROTOCOL = 16'd9;
   localparam logic [15:0] IDX_SRC_FIRST = 16'd12;
   localparam logic [15:0] IDX_SRC_LAST  = 16'd15;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_SIZE     = 2'd1,
      STATUS_BAD_CHECKSUM = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] payload_length;
      logic [31:0] source_address;
      logic [7:0]  protocol_number;
      logic [31:0] bad_size_total;
      logic [31:0] bad_checksum_total;
   } rsp_item_type;

endpackage

[design/ipv4hv_datapath.sv]
module ipv4hv_datapath import ipv4hv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  pending_high_byte_ff, pending_high_byte_in;
   logic [5:0]  header_bytes_ff, header_bytes_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [31:0] source_latch_ff, source_latch_in;
   logic [7:0]  protocol_latch_ff, protocol_latch_in;
   logic [31:0] bad_size_count_ff, bad_size_count_in;
   logic [31:0] bad_checksum_count_ff, bad_checksum_count_in;

   logic [15:0] idx;
   logic [5:0]  hdr_cur;
   logic [15:0] hdr_wide;
   logic [16:0] sum_wide;
   logic [15:0] sum_upd;
   logic [15:0] total_upd;
   logic [31:0] source_upd;
   logic [7:0]  protocol_upd;
   logic [15:0] size_upd;
   logic        bad_size;
   logic        bad_checksum;

   always_comb begin
      idx      = byte_count_ff;
      hdr_cur  = (idx == 16'd0) ? {item.data_byte[3:0], 2'b00} : header_bytes_ff;
      hdr_wide = {10'd0, hdr_cur};

      // ones' complement add with end-around carry
      sum_wide = {1'b0, running_sum_ff} + {1'b0, pending_high_byte_ff, item.data_byte};
      sum_upd  = running_sum_ff;
      pending_high_byte_in = pending_high_byte_ff;
      if (idx < hdr_wide) begin
         if (!idx[0]) begin
            pending_high_byte_in = item.data_byte;
         end else begin
            sum_upd = sum_wide[15:0] + {15'd0, sum_wide[16]};
         end
      end

      total_upd    = total_length_ff;
      protocol_upd = protocol_latch_ff;
      source_upd   = source_latch_ff;
      if (idx == IDX_TOTAL_HI) begin
         total_upd = {item.data_byte, total_length_ff[7:0]};
      end else if (idx == IDX_TOTAL_LO) begin
         total_upd = {total_length_ff[15:8], item.data_byte};
      end else if (idx == IDX_PROTOCOL) begin
         protocol_upd = item.data_byte;
      end else if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST) begin
         source_upd = {source_latch_ff[23:0], item.data_byte};
      end

      size_upd = (byte_count_ff == BYTE_COUNT_MAX) ? byte_count_ff : byte_count_ff + 16'd1;

      bad_size     = (size_upd < MIN_HEADER_BYTES) || (size_upd < hdr_wide);
      bad_checksum = !bad_size && (sum_upd != SUM_ALL_ONES);

      bad_size_count_in     = bad_size_count_ff;
      bad_checksum_count_in = bad_checksum_count_ff;
      if (item.last && bad_size) begin
         bad_size_count_in = bad_size_count_ff + 32'd1;
      end
      if (item.last && bad_checksum) begin
         bad_checksum_count_in = bad_checksum_count_ff + 32'd1;
      end

      result.payload_length  = 16'd0;
      result.source_address  = 32'd0;
      result.protocol_number = 8'd0;
      if (bad_size) begin
         result.status = STATUS_BAD_SIZE;
      end else if (bad_checksum) begin
         result.status = STATUS_BAD_CHECKSUM;
      end else begin
         result.status          = STATUS_OK;
         result.payload_length  = (total_upd > hdr_wide) ? total_upd - hdr_wide : 16'd0;
         result.source_address  = source_upd;
         result.protocol_number = protocol_upd;
      end
      result.bad_size_total     = bad_size_count_in;
      result.bad_checksum_total = bad_checksum_count_in;

      // the final byte clears all per-packet state
      if (item.last) begin
         running_sum_in       = 16'd0;
         byte_count_in        = 16'd0;
         pending_high_byte_in = 8'd0;
         header_bytes_in      = 6'd0;
         total_length_in      = 16'd0;
         source_latch_in      = 32'd0;
         protocol_latch_in    = 8'd0;
      end else begin
         running_sum_in    = sum_upd;
         byte_count_in     = size_upd;
         header_bytes_in   = hdr_cur;
         total_length_in   = total_upd;
         source_latch_in   = source_upd;
         protocol_latch_in = protocol_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff        <= '0;
         byte_count_ff         <= '0;
         pending_high_byte_ff  <= '0;
         header_bytes_ff       <= '0;
         total_length_ff       <= '0;
         source_latch_ff       <= '0;
         protocol_latch_ff     <= '0;
         bad_size_count_ff     <= '0;
         bad_checksum_count_ff <= '0;
      end else if (fire) begin
         running_sum_ff        <= running_sum_in;
         byte_count_ff         <= byte_count_in;
         pending_high_byte_ff  <= pending_high_byte_in;
         header_bytes_ff       <= header_bytes_in;
         total_length_ff       <= total_length_in;
         source_latch_ff       <= source_latch_in;
         protocol_latch_ff     <= protocol_latch_in;
         bad_size_count_ff     <= bad_size_count_in;
         bad_checksum_count_ff <= bad_checksum_count_in;
      end
   end

endmodule

[design/ipv4_header_validator.sv]
// channel  | direction | ports                         | moves
// req      | in        | req_valid req_stall req_item  | one packet byte with last marker
// rsp      | out       | rsp_valid rsp_stall rsp_item  | one verdict per packet, on last byte
//
// one byte per cycle sustained unless a final byte waits on a stalled result: input
// register, one pass of checksum/size logic, result register.
// reset is synchronous; it clears both stages, per-packet state and the counters.
// a stalled result holds only the final byte; other bytes keep flowing.
// req_stall rises when a final byte waits on a result register that is stalled.
`include "ipv4_header_validator_macros.svh"

module ipv4_header_validator import ipv4hv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type verdict;
   logic         out_free;
   logic         proc_fire;
   logic         req_fire;
   logic         last_fire;
   logic         rsp_rejected;
   logic         rsp_fields_clear;
   logic         last_blocked;

   ipv4hv_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .fire   (proc_fire),
      .item   (in_item_ff),
      .result (verdict)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      // only a final byte needs room in the result register
      proc_fire = in_valid_ff && (!in_item_ff.last || out_free);
      req_stall = in_valid_ff && !proc_fire;
      req_fire  = req_valid && !req_stall;

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (proc_fire && in_item_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (proc_fire && in_item_ff.last) begin
         rsp_item_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign last_fire        = proc_fire && in_item_ff.last;
   assign rsp_rejected     = rsp_valid_ff && rsp_item_ff.status != STATUS_OK;
   assign rsp_fields_clear = rsp_item_ff.payload_length == 16'd0 &&
                             rsp_item_ff.source_address == 32'd0 &&
                             rsp_item_ff.protocol_number == 8'd0;
   assign last_blocked     = in_valid_ff && in_item_ff.last && rsp_valid_ff && rsp_stall;

   `IPV4HV_ASSERT_NEXT(a_last_gives_result, clock, reset, last_fire, rsp_valid_ff)
   `IPV4HV_ASSERT_NOW(a_reject_fields_zero, clock, reset, rsp_rejected, rsp_fields_clear)
   `IPV4HV_ASSERT_NOW(a_blocked_last_stalls, clock, reset, last_blocked, req_stall && !proc_fire)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import ipv4hv_pkg::*;

   localparam int DIR_ROWS     = 23;
   localparam int RANDOM_BYTES = 1550;
   localparam int MIN_PACKETS  = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0]   data_byte;
      logic         last;
      logic         typed;
      rsp_item_type verdict;
   } dir_row_type;

   localparam rsp_item_type NO_VERDICT = '0;
   // single runt byte right after reset
   localparam rsp_item_type RUNT_FIRST =
      {STATUS_BAD_SIZE, 16'd0, 32'd0, 8'd0, 32'd1, 32'd0};
   // clean 20-byte header, total length 16 is below the header length
   localparam rsp_item_type CLEAN_SHORT_TOTAL =
      {STATUS_OK, 16'd0, 32'hFFFF_FFFF, 8'hFF, 32'd1, 32'd0};
   // two-byte runt with a zero header length
   localparam rsp_item_type RUNT_SECOND =
      {STATUS_BAD_SIZE, 16'd0, 32'd0, 8'd0, 32'd2, 32'd0};

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      {8'hFF, 1'b1, 1'b1, RUNT_FIRST},
      {8'h45, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h10, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h40, 1'b0, 1'b0, NO_VERDICT},
      {8'hFF, 1'b0, 1'b0, NO_VERDICT},
      {8'h79, 1'b0, 1'b0, NO_VERDICT},
      {8'hF0, 1'b0, 1'b0, NO_VERDICT},
      {8'hFF, 1'b0, 1'b0, NO_VERDICT},
      {8'hFF, 1'b0, 1'b0, NO_VERDICT},
      {8'hFF, 1'b0, 1'b0, NO_VERDICT},
      {8'hFF, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h00, 1'b1, 1'b1, CLEAN_SHORT_TOTAL},
      {8'h00, 1'b0, 1'b0, NO_VERDICT},
      {8'h4F, 1'b1, 1'b1, RUNT_SECOND}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   // predictor state
   logic [15:0] sum_acc = '0;
   logic [15:0] byte_idx = '0;
   logic [7:0]  hi_byte = '0;
   logic [5:0]  hdr_len = '0;
   logic [15:0] total_len = '0;
   logic [31:0] src_addr = '0;
   logic [7:0]  proto_byte = '0;
   logic [31:0] bad_size_cnt = '0;
   logic [31:0] bad_csum_cnt = '0;

   rsp_item_type verdict_q [$];
   rsp_item_type calc_verdict;
   rsp_item_type want_verdict;
   bit           made_verdict;
   logic [7:0]   pkt_bytes [$];

   int bytes_taken = 0;
   int verdicts_seen = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int bytes_sent = 0;
   int packets_sent = 0;
   bit idle_enable = 1'b1;
   bit hold_done = 1'b0;

   ipv4_header_validator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[15:0] + {15'd0, wide[16]};
   endfunction

   task automatic clear_packet();
      sum_acc    = '0;
      byte_idx   = '0;
      hi_byte    = '0;
      hdr_len    = '0;
      total_len  = '0;
      src_addr   = '0;
      proto_byte = '0;
   endtask

   // advance the header checker by one byte; a verdict comes out on the last one
   task automatic fold_byte(input req_item_type item, output bit done,
                            output rsp_item_type verdict);
      logic [15:0] idx;
      idx = byte_idx;
      verdict = '0;
      if (idx == 16'd0) hdr_len = {item.data_byte[3:0], 2'b00};
      if (idx < {10'd0, hdr_len}) begin
         if (!idx[0]) hi_byte = item.data_byte;
         else sum_acc = ones_add16(sum_acc, {hi_byte, item.data_byte});
      end
      if (idx == IDX_TOTAL_HI) total_len[15:8] = item.data_byte;
      else if (idx == IDX_TOTAL_LO) total_len[7:0] = item.data_byte;
      else if (idx == IDX_PROTOCOL) proto_byte = item.data_byte;
      else if (idx >= IDX_SRC_FIRST && idx <= IDX_SRC_LAST)
         src_addr = {src_addr[23:0], item.data_byte};
      if (byte_idx != BYTE_COUNT_MAX) byte_idx = byte_idx + 16'd1;
      done = item.last;
      if (item.last) begin
         if (byte_idx < MIN_HEADER_BYTES || byte_idx < {10'd0, hdr_len}) begin
            verdict.status = STATUS_BAD_SIZE;
            bad_size_cnt = bad_size_cnt + 32'd1;
         end else if (sum_acc != SUM_ALL_ONES) begin
            verdict.status = STATUS_BAD_CHECKSUM;
            bad_csum_cnt = bad_csum_cnt + 32'd1;
         end else begin
            verdict.status = STATUS_OK;
            if (total_len > {10'd0, hdr_len})
               verdict.payload_length = total_len - {10'd0, hdr_len};
            verdict.source_address  = src_addr;
            verdict.protocol_number = proto_byte;
         end
         verdict.bad_size_total     = bad_size_cnt;
         verdict.bad_checksum_total = bad_csum_cnt;
         clear_packet();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // scoreboard: predict on every accepted byte, compare on every accepted verdict
   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         bad_size_cnt = '0;
         bad_csum_cnt = '0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_byte(req_item, made_verdict, calc_verdict);
            if (bytes_taken < DIR_ROWS && DIR_TABLE[bytes_taken].typed)
               calc_verdict = DIR_TABLE[bytes_taken].verdict;
            if (made_verdict) verdict_q.push_back(calc_verdict);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with no packet pending: status %0d", rsp_item.status);
               errors++;
            end else begin
               want_verdict = verdict_q.pop_front();
               check_field("status", want_verdict.status, rsp_item.status);
               check_field("payload_length", want_verdict.payload_length,
                           rsp_item.payload_length);
               check_field("source_address", want_verdict.source_address,
                           rsp_item.source_address);
               check_field("protocol_number", want_verdict.protocol_number,
                           rsp_item.protocol_number);
               check_field("bad_size_total", want_verdict.bad_size_total,
                           rsp_item.bad_size_total);
               check_field("bad_checksum_total", want_verdict.bad_checksum_total,
                           rsp_item.bad_checksum_total);
            end
            verdicts_seen <= verdicts_seen + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // verdict side: random stalls, plus one long hold so the final byte backs up
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && verdicts_seen == 10) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= idle_enable && ($urandom_range(99) < 7);
      end
   end

   task automatic drive_byte(input req_item_type item);
      while (idle_enable && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet();
      req_item_type item;
      for (int k = 0; k < pkt_bytes.size(); k++) begin
         item.data_byte = pkt_bytes[k];
         item.last      = (k == pkt_bytes.size() - 1);
         drive_byte(item);
         bytes_sent++;
      end
      packets_sent++;
   endtask

   // header with a correct checksum when it holds at least one word, followed by random body bytes
   task automatic build_valid_packet(input int ihl, input int body, input logic [15:0] total);
      logic [15:0] acc;
      int          hdr;
      int          fix;
      hdr = ihl * 4;
      pkt_bytes.delete();
      for (int k = 0; k < hdr + body; k++) pkt_bytes.push_back(8'($urandom_range(255)));
      pkt_bytes[0] = {pkt_bytes[0][7:4], 4'(ihl)};
      pkt_bytes[2] = total[15:8];
      pkt_bytes[3] = total[7:0];
      if (hdr >= 4) begin
         // short headers carry the correction word in their last word
         fix = (hdr >= 12) ? 10 : hdr - 2;
         pkt_bytes[fix]     = 8'h00;
         pkt_bytes[fix + 1] = 8'h00;
         acc = '0;
         for (int k = 0; k < hdr; k += 2)
            acc = ones_add16(acc, {pkt_bytes[k], pkt_bytes[k + 1]});
         acc = ~acc;
         pkt_bytes[fix]     = acc[15:8];
         pkt_bytes[fix + 1] = acc[7:0];
      end
   endtask

   task automatic pick_packet();
      int          sel;
      int          ihl;
      int          hdr;
      int          body;
      int          keep;
      int          pos;
      logic [15:0] total;
      sel  = $urandom_range(99);
      ihl  = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
      hdr  = ihl * 4;
      body = (hdr < 20) ? 20 - hdr + $urandom_range(12) : $urandom_range(24);
      case ($urandom_range(3))
         0: total = 16'($urandom_range(16'hFFFF));
         1: total = (hdr == 0) ? 16'd0 : 16'($urandom_range(hdr - 1));
         default: total = 16'(hdr + body);
      endcase
      build_valid_packet(ihl, body, total);
      if (sel < 65) begin
      end else if (sel < 78) begin
         // corrupt one bit somewhere in the packet
         pos = $urandom_range(pkt_bytes.size() - 1);
         pkt_bytes[pos] = pkt_bytes[pos] ^ (8'h01 << $urandom_range(7));
      end else if (sel < 88) begin
         keep = $urandom_range(pkt_bytes.size() - 1, 1);
         while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end else begin
         pkt_bytes.delete();
         keep = $urandom_range(40, 1);
         for (int k = 0; k < keep; k++) pkt_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin
      req_item_type item;
      req_valid   <= 1'b0;
      req_item    <= '0;
      reset       <= 1'b1;
      idle_enable <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         item.data_byte = DIR_TABLE[r].data_byte;
         item.last      = DIR_TABLE[r].last;
         drive_byte(item);
      end

      bytes_sent   = 0;
      packets_sent = 0;
      while (bytes_sent < RANDOM_BYTES || packets_sent < MIN_PACKETS) begin
         // a run of packets with no gaps on either side
         idle_enable <= !(packets_sent >= 15 && packets_sent < 40);
         pick_packet();
         send_packet();
      end
      idle_enable <= 1'b1;
      req_valid <= 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[ipv4_header_validator.f]
+incdir+design
design/ipv4hv_pkg.sv
design/ipv4hv_datapath.sv
design/ipv4_header_validator.sv
tb/tb_top.sv
